// ===== rtl/gnss_info_response_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// GNSS info response parser assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GNSS_INFO_RESPONSE_PARSER_UNIT_MACROS_SVH
`define GNSS_INFO_RESPONSE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GIPU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GIPU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gipu_pkg.sv =====
// ----------------------------------------------------------------------------
// GNSS info response parser package
// Constants, command types and a helper function shared by the parser modules.
// ----------------------------------------------------------------------------
package gipu_pkg;

  localparam int unsigned MaxResponseBytes = 1024;
  localparam int unsigned IdxW             = $clog2(MaxResponseBytes + 1);
  localparam int unsigned FieldLimit       = 7;
  localparam int unsigned DatetimeLength   = 18;
  localparam int unsigned DateDigits       = 14;
  localparam int unsigned DatePartCount    = 6;
  localparam int unsigned DatePartW        = 14;
  localparam int unsigned ValueW           = 40;
  localparam int unsigned MagW             = ValueW - 1;
  localparam int unsigned Pow10W           = 20;
  localparam int unsigned ProdW            = MagW + Pow10W;
  localparam int unsigned IdW              = 4;
  localparam int unsigned InDataW          = 8;
  localparam int unsigned OutDataW         = 48;
  localparam int unsigned CfgDataW         = 10;
  localparam int unsigned FifoDepth        = 4;
  localparam int unsigned FifoPtrW         = $clog2(FifoDepth);

  localparam logic [MagW-1:0] MagCap        = '1;
  localparam logic [2:0]      MaxFracDigits = 3'd6;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPoint = 8'h2E;

  localparam logic CfgStatusPos  = 1'b0;
  localparam logic CfgFracDigits = 1'b1;

  localparam logic [IdW-1:0] FidRun    = 4'd0;
  localparam logic [IdW-1:0] FidFix    = 4'd1;
  localparam logic [IdW-1:0] FidYear   = 4'd2;
  localparam logic [IdW-1:0] FidSecond = 4'd7;
  localparam logic [IdW-1:0] FidLat    = 4'd8;

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_NUMBER,
    CMD_DATE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCALE,
    BK_DATE
  } bk_state_e;

  typedef struct packed {
    cmd_kind_e                                  kind;
    logic [IdW-1:0]                             id;
    logic [ValueW-1:0]                          value;
    logic [2:0]                                 scale;
    logic                                       neg;
    logic [DatePartCount-1:0][DatePartW-1:0]    parts;
  } cmd_t;

  function automatic logic [Pow10W-1:0] pow10(input logic [2:0] k);
    logic [Pow10W-1:0] r;
    unique case (k)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gipu_fifo.sv =====
// ----------------------------------------------------------------------------
// GNSS info response parser command queue
// Small register queue of parsed commands between the front and back parts.
// ----------------------------------------------------------------------------
module gipu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gipu_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output gipu_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import gipu_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FifoPtrW + 1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/gipu_front.sv =====
// ----------------------------------------------------------------------------
// GNSS info response parser front end
// Accepts response bytes, tracks fields and queues result commands.
// ----------------------------------------------------------------------------
module gipu_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
  input  logic                     s_axis_tuser,  // [0] first_byte
  input  logic                     s_axis_tlast,  // last_byte
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [9:0]               cfg_data_i,
  input  logic                     full_i,
  output logic                     push_o,
  output gipu_pkg::cmd_t           cmd_o
);
  import gipu_pkg::*;

  logic [CfgDataW-1:0] sp_q;
  logic [2:0]          fd_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                en_q, en_d;
  logic [2:0]          comma_q, comma_d;
  logic [4:0]          off_q, off_d;
  logic [MagW-1:0]     acc_q, acc_d;
  logic [2:0]          fcnt_q, fcnt_d;
  logic                neg_q, neg_d;
  logic                point_q, point_d;
  logic                ended_q, ended_d;
  logic                stopped_q, stopped_d;
  logic [DatePartCount-1:0][DatePartW-1:0] parts_q, parts_d;

  logic                accept;
  logic                first;
  logic                is_digit;
  logic [3:0]          dig;
  logic [2:0]          fd_clip;
  logic [IdxW-1:0]     eff_idx;
  logic                eff_en;
  logic                eff_ended;
  logic [2:0]          eff_comma;
  logic [4:0]          eff_off;
  logic [MagW-1:0]     eff_acc;
  logic [2:0]          eff_fcnt;
  logic                eff_neg;
  logic                eff_point;
  logic                eff_stopped;
  logic [IdxW-1:0]     sp_ext;
  logic [4:0]          off_lo;
  logic [2:0]          part_sel;
  logic                part_first;
  logic [DatePartW-1:0] dval;

  function automatic logic [MagW-1:0] mul10_sat(input logic [MagW-1:0] m,
                                                input logic [3:0] d);
    logic [MagW+3:0] w;
    w = (MagW + 4)'({m, 3'b000}) + (MagW + 4)'({m, 1'b0}) + (MagW + 4)'(d);
    return (w > (MagW + 4)'(MagCap)) ? MagCap : w[MagW-1:0];
  endfunction

  assign s_axis_tready = !full_i;
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign first         = s_axis_tuser;

  assign is_digit = (s_axis_tdata >= CharZero) && (s_axis_tdata <= CharNine);
  assign dig      = 4'(s_axis_tdata - CharZero);
  assign fd_clip  = (fd_q > MaxFracDigits) ? MaxFracDigits : fd_q;
  assign sp_ext   = IdxW'(sp_q);
  assign dval     = {6'd0, s_axis_tdata} - 14'd48;

  assign eff_idx     = first ? '0 : idx_q;
  assign eff_en      = first ? 1'b0 : en_q;
  assign eff_ended   = first ? 1'b0 : ended_q;
  assign eff_comma   = first ? '0 : comma_q;
  assign eff_off     = first ? '0 : off_q;
  assign eff_acc     = first ? '0 : acc_q;
  assign eff_fcnt    = first ? '0 : fcnt_q;
  assign eff_neg     = first ? 1'b0 : neg_q;
  assign eff_point   = first ? 1'b0 : point_q;
  assign eff_stopped = first ? 1'b0 : stopped_q;

  assign off_lo     = eff_off - 5'd4;
  assign part_sel   = (eff_off < 5'd4) ? 3'd0 : 3'(off_lo[4:1]) + 3'd1;
  assign part_first = (eff_off < 5'd4) ? (eff_off == 5'd0) : !eff_off[0];

  always_comb begin
    idx_d     = idx_q;
    en_d      = en_q;
    comma_d   = comma_q;
    off_d     = off_q;
    acc_d     = acc_q;
    fcnt_d    = fcnt_q;
    neg_d     = neg_q;
    point_d   = point_q;
    ended_d   = ended_q;
    stopped_d = stopped_q;
    parts_d   = parts_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    if (accept) begin
      en_d      = eff_en;
      comma_d   = eff_comma;
      off_d     = eff_off;
      acc_d     = eff_acc;
      fcnt_d    = eff_fcnt;
      neg_d     = eff_neg;
      point_d   = eff_point;
      ended_d   = eff_ended;
      stopped_d = eff_stopped;
      idx_d     = (eff_idx < IdxW'(MaxResponseBytes)) ? eff_idx + 1'b1 : eff_idx;
      if (!eff_ended && (eff_idx < IdxW'(MaxResponseBytes))) begin
        if (s_axis_tlast) begin
          ended_d = 1'b1;
          en_d    = 1'b0;
        end else if (eff_idx == sp_ext) begin
          en_d      = is_digit;
          comma_d   = '0;
          off_d     = '0;
          acc_d     = '0;
          fcnt_d    = '0;
          neg_d     = 1'b0;
          point_d   = 1'b0;
          stopped_d = 1'b0;
          if (is_digit) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_SINGLE;
            cmd_o.id     = FidRun;
            cmd_o.value  = {32'd0, s_axis_tdata} - 40'd48;
          end
        end else if ((eff_idx > sp_ext) && eff_en && (eff_comma < 3'(FieldLimit))) begin
          if ((s_axis_tdata == CharComma) && !((eff_comma == 3'd2) && (eff_off != '0)))
          begin
            if ((eff_comma >= 3'd3) && (eff_comma <= 3'd6) && (eff_off != '0)) begin
              push_o      = 1'b1;
              cmd_o.kind  = CMD_NUMBER;
              cmd_o.id    = FidLat + 4'(eff_comma - 3'd3);
              cmd_o.value = ValueW'(eff_acc);
              cmd_o.scale = (eff_fcnt < fd_clip) ? fd_clip - eff_fcnt : 3'd0;
              cmd_o.neg   = eff_neg;
            end
            comma_d   = eff_comma + 1'b1;
            off_d     = '0;
            acc_d     = '0;
            fcnt_d    = '0;
            neg_d     = 1'b0;
            point_d   = 1'b0;
            stopped_d = 1'b0;
          end else if (eff_comma == 3'd1) begin
            push_o      = 1'b1;
            cmd_o.kind  = CMD_SINGLE;
            cmd_o.id    = FidFix;
            cmd_o.value = {32'd0, s_axis_tdata} - 40'd48;
          end else if (eff_comma == 3'd2) begin
            if (eff_off < 5'(DateDigits)) begin
              if (part_first) begin
                parts_d[part_sel] = dval;
              end else begin
                parts_d[part_sel] = DatePartW'(parts_q[part_sel] * 4'd10 + dval);
              end
            end
            if (eff_off == 5'(DateDigits - 1)) begin
              push_o      = 1'b1;
              cmd_o.kind  = CMD_DATE;
              cmd_o.id    = FidYear;
              cmd_o.parts = parts_d;
            end
            off_d = (eff_off == 5'(DatetimeLength - 1)) ? '0 : eff_off + 1'b1;
          end else if ((eff_comma >= 3'd3) && (eff_comma <= 3'd6)) begin
            if (!eff_stopped) begin
              if ((eff_off == '0) &&
                  ((s_axis_tdata == CharMinus) || (s_axis_tdata == CharPlus))) begin
                neg_d = eff_neg || (s_axis_tdata == CharMinus);
              end else if (is_digit) begin
                if (eff_point) begin
                  if (eff_fcnt < fd_clip) begin
                    acc_d  = mul10_sat(eff_acc, dig);
                    fcnt_d = eff_fcnt + 1'b1;
                  end
                end else begin
                  acc_d = mul10_sat(eff_acc, dig);
                end
              end else if ((s_axis_tdata == CharPoint) && !eff_point) begin
                point_d = 1'b1;
              end else begin
                stopped_d = 1'b1;
              end
            end
            off_d = (eff_off < 5'd31) ? eff_off + 1'b1 : eff_off;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= 10'd12;
      fd_q      <= 3'd6;
      idx_q     <= '0;
      en_q      <= 1'b0;
      comma_q   <= '0;
      off_q     <= '0;
      acc_q     <= '0;
      fcnt_q    <= '0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      ended_q   <= 1'b0;
      stopped_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgStatusPos) begin
          sp_q <= cfg_data_i;
        end else if (cfg_index_i == CfgFracDigits) begin
          fd_q <= cfg_data_i[2:0];
        end
      end
      idx_q     <= idx_d;
      en_q      <= en_d;
      comma_q   <= comma_d;
      off_q     <= off_d;
      acc_q     <= acc_d;
      fcnt_q    <= fcnt_d;
      neg_q     <= neg_d;
      point_q   <= point_d;
      ended_q   <= ended_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    parts_q <= parts_d;
  end

endmodule

// ===== rtl/gipu_back.sv =====
// ----------------------------------------------------------------------------
// GNSS info response parser back end
// Pops queued commands, scales decimals, bursts date parts and drives results.
// ----------------------------------------------------------------------------
`include "gnss_info_response_parser_unit_macros.svh"

module gipu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  gipu_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [47:0]    m_axis_tdata,  // [3:0] field_id, [43:4] field_value
  output logic           m_axis_tlast   // last_of_run
);
  import gipu_pkg::*;

  bk_state_e           st_q, st_d;
  logic                ov_q, ov_d;
  logic [IdW-1:0]      oid_q, oid_d;
  logic [ValueW-1:0]   oval_q, oval_d;
  logic                olast_q, olast_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic                nneg_q, nneg_d;
  logic [IdW-1:0]      nid_q, nid_d;
  logic [DatePartCount-1:0][DatePartW-1:0] dparts_q, dparts_d;
  logic [2:0]          cnt_q, cnt_d;

  logic                can_load;
  logic                take;
  logic                date_done;
  logic [MagW-1:0]     sat;
  logic [ValueW-1:0]   mag;

  assign can_load  = !ov_q || m_axis_tready;
  assign take      = (st_q == BK_IDLE) && !empty_i &&
                     ((head_i.kind != CMD_SINGLE) || can_load);
  assign pop_o     = take;
  assign date_done = (cnt_q == 3'(DatePartCount - 1));
  assign sat       = (prod_q > ProdW'(MagCap)) ? MagCap : prod_q[MagW-1:0];
  assign mag       = ValueW'(sat);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (take) begin
          unique case (head_i.kind)
            CMD_NUMBER: st_d = BK_SCALE;
            CMD_DATE:   st_d = BK_DATE;
            default:    st_d = BK_IDLE;
          endcase
        end
      end
      BK_SCALE: begin
        if (can_load) begin
          st_d = BK_IDLE;
        end
      end
      BK_DATE: begin
        if (can_load && date_done) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ov_d     = ov_q && !m_axis_tready;
    oid_d    = oid_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    prod_d   = prod_q;
    nneg_d   = nneg_q;
    nid_d    = nid_q;
    dparts_d = dparts_q;
    cnt_d    = cnt_q;
    unique case (st_q)
      BK_IDLE: begin
        if (take) begin
          unique case (head_i.kind)
            CMD_SINGLE: begin
              ov_d    = 1'b1;
              oid_d   = head_i.id;
              oval_d  = head_i.value;
              olast_d = 1'b1;
            end
            CMD_NUMBER: begin
              prod_d = ProdW'(head_i.value[MagW-1:0]) * ProdW'(pow10(head_i.scale));
              nneg_d = head_i.neg;
              nid_d  = head_i.id;
            end
            CMD_DATE: begin
              dparts_d = head_i.parts;
              cnt_d    = '0;
            end
            default: begin
              cnt_d = cnt_q;
            end
          endcase
        end
      end
      BK_SCALE: begin
        if (can_load) begin
          ov_d    = 1'b1;
          oid_d   = nid_q;
          oval_d  = nneg_q ? ('0 - mag) : mag;
          olast_d = 1'b1;
        end
      end
      BK_DATE: begin
        if (can_load) begin
          ov_d     = 1'b1;
          oid_d    = FidYear + IdW'(cnt_q);
          oval_d   = {{(ValueW - DatePartW){dparts_q[0][DatePartW-1]}}, dparts_q[0]};
          olast_d  = date_done;
          dparts_d = dparts_q >> DatePartW;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      default: begin
        ov_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oid_q    <= oid_d;
    oval_q   <= oval_d;
    olast_q  <= olast_d;
    prod_q   <= prod_d;
    nneg_q   <= nneg_d;
    nid_q    <= nid_d;
    dparts_q <= dparts_d;
    cnt_q    <= cnt_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {(OutDataW - ValueW - IdW)'(0), oval_q, oid_q};
  assign m_axis_tlast  = olast_q;

  `GIPU_ASSERT_NOW(a_pop_nonempty, pop_o, !empty_i, "command popped from empty queue")
  `GIPU_ASSERT_NEXT(a_number_scales, (st_q == BK_IDLE) && pop_o && (head_i.kind == CMD_NUMBER), st_q == BK_SCALE, "number command did not enter scaling")
  `GIPU_ASSERT_NOW(a_second_is_last, ov_q && (oid_q == FidSecond), olast_q, "date burst not closed on second")
  `GIPU_ASSERT_NOW(a_date_not_last, ov_q && (oid_q >= FidYear) && (oid_q < FidSecond), !olast_q, "date burst closed early")

endmodule

// ===== rtl/gnss_info_response_parser_unit.sv =====
// ----------------------------------------------------------------------------
// GNSS info response parser
// Byte-stream parser of a GNSS info response into numbered field results.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one response byte per transfer; tuser marks the first byte
//   of a response, tlast the final byte, which is never parsed.
//   m_axis carries one result per transfer: field id and signed value; tlast
//   marks the final result caused by one input byte.
//   cfg_* writes status_position (index 0) and fraction_digits (index 1);
//   cfg_ready_o is always high. Write only while the block is idle.
// Throughput: one byte per cycle while the command queue is not full, set by
//   the front part's field tracker. The last date digit causes a burst of six
//   results, one a cycle while m_axis is ready. Run and fix results pass the
//   command queue and the output register; decimal results also pass the back
//   part's scaling multiplier register, and date parts its date part register.
// The 4-entry command queue absorbs bursts; s_axis_tready drops when it is full.
// A stalled m_axis holds its result and fills the queue; input then stalls.
// Reset sets status_position to 12 and fraction_digits to 6, clears the
//   parse state, and treats the next byte as index zero.
// ----------------------------------------------------------------------------
module gnss_info_response_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [3:0] field_id, [43:4] field_value
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  import gipu_pkg::*;

  logic full;
  logic empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  gipu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  gipu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  gipu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
